// ----- hdl/cleb_pkg.sv -----
// Shared types and character codes for the console line editor buffer.
`default_nettype none
package cleb_pkg;

    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [2:0] {
        K_ECHO  = 3'd0,
        K_DATA  = 3'd1,
        K_EOF   = 3'd2,
        K_EMPTY = 3'd3,
        K_NONE  = 3'd4
    } t_kind;

    // where the byte of an emitted result comes from
    typedef enum logic [2:0] {
        SRC_ZERO  = 3'd0,
        SRC_ITEM  = 3'd1,
        SRC_BS    = 3'd2,
        SRC_SP    = 3'd3,
        SRC_CR    = 3'd4,
        SRC_RDATA = 3'd5,
        SRC_PEND  = 3'd6
    } t_src;

    typedef struct packed {
        logic  load;
        logic  rx_store;
        logic  rx_del;
        logic  rd_fetch;
        logic  rd_consume;
        logic  emit;
        t_kind kind;
        t_src  src;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic op;
        logic item_zero;
        logic item_del;
        logic item_lf;
        logic can_erase;
        logic full;
        logic n_zero;
        logic empty;
        logic rdata_ctl;
        logic rdata_lf;
        logic last_take;
        logic rd_next_cm;
    } t_stat;

endpackage
`default_nettype wire

// ----- hdl/cleb_in_if.sv -----
// Input channel: receive byte or read request, valid/ready handshake.
`default_nettype none
interface cleb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;
    logic [6:0] read_length;

    modport source (output valid, operation, rx_byte, read_length, input ready);
    modport sink   (input valid, operation, rx_byte, read_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/cleb_out_if.sv -----
// Output channel: echo and read results, valid/ready handshake.
`default_nettype none
interface cleb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, kind, out_byte, last, input ready);
    modport sink   (input valid, kind, out_byte, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/console_line_editor_buffer_unit.sv -----
// Console input ring buffer with line editing: top level.
//
// Channels: i_in carries one transaction per item, either a received byte
// (operation 0) or a read request of up to read_length bytes (operation 1).
// o_out carries the results: echo bytes, read data, end-of-input marks, an
// empty-buffer mark or a no-op mark; last is set on the final result of
// each item. Every item yields at least one result.
// Timing: an item is taken when the controller is idle. A plain received
// byte yields one echo, an LF two and an erase three (one result per cycle
// after dispatch while the output register is free). A read walks the line
// store through its registered read port and holds each data byte but the
// final one back as look-ahead until the next byte is fetched. An empty or
// zero-length read yields a single mark.
// Results leave through one output register; when the receiver stalls the
// controller waits on it, and the next item is accepted as soon as the
// last result of the current one is in that register.
// Reset clears the three ring pointers and the output valid; the line store
// is not cleared, as only written entries are ever read.
`default_nettype none
module console_line_editor_buffer_unit #(
    parameter int BUFFER_DEPTH = 512,
    parameter int MAX_READ     = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cleb_in_if.sink    i_in,
    cleb_out_if.source o_out
);
    import cleb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    cleb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cleb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_READ     (MAX_READ)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_in.operation),
        .i_rx_byte     (i_in.rx_byte),
        .i_read_length (i_in.read_length),
        .o_out         (o_out)
    );

    assign i_in.ready = in_ready;
endmodule
`default_nettype wire

// ----- hdl/cleb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hdl/cleb_datapath.sv -----
// Datapath: ring pointers, line store, read bookkeeping and output register.
`default_nettype none
module cleb_datapath #(
    parameter int BUFFER_DEPTH = 512,
    parameter int MAX_READ     = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cleb_pkg::t_cmd      i_cmd,
    output cleb_pkg::t_stat     o_stat,
    input  wire logic           i_operation,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [6:0]     i_read_length,
    cleb_out_if.source          o_out
);
    import cleb_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LastIdx = AW'(BUFFER_DEPTH - 1);
    localparam logic [6:0] MaxLen = 7'(MAX_READ);

    // pointers: store index plus a wrap bit, i.e. modulo twice the depth
    logic [AW-1:0] r_rd_idx, r_cm_idx, r_ed_idx;
    logic          r_rd_wrap, r_cm_wrap, r_ed_wrap;
    logic          r_op;
    logic [7:0]    r_byte;
    logic [6:0]    r_len;
    logic [6:0]    r_taken;
    logic [7:0]    r_pend;
    logic          r_out_valid;
    logic [2:0]    r_out_kind;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [AW-1:0] ed_inc_idx, ed_dec_idx, rd_inc_idx;
    logic          ed_inc_wrap, ed_dec_wrap, rd_inc_wrap;
    logic [7:0]    item_c;
    logic [7:0]    rdata;
    logic [7:0]    emit_byte;
    logic [6:0]    len_cap;
    logic          out_free;
    logic          item_commit;
    logic          full, full_after;

    always_comb begin
        ed_inc_idx  = (r_ed_idx == LastIdx) ? '0 : r_ed_idx + 1'b1;
        ed_inc_wrap = (r_ed_idx == LastIdx) ? ~r_ed_wrap : r_ed_wrap;
        ed_dec_idx  = (r_ed_idx == '0) ? LastIdx : r_ed_idx - 1'b1;
        ed_dec_wrap = (r_ed_idx == '0) ? ~r_ed_wrap : r_ed_wrap;
        rd_inc_idx  = (r_rd_idx == LastIdx) ? '0 : r_rd_idx + 1'b1;
        rd_inc_wrap = (r_rd_idx == LastIdx) ? ~r_rd_wrap : r_rd_wrap;
    end

    assign item_c      = (r_byte == CH_CR) ? CH_LF : r_byte;
    assign full        = (r_ed_idx == r_rd_idx) && (r_ed_wrap != r_rd_wrap);
    assign full_after  = (ed_inc_idx == r_rd_idx) && (ed_inc_wrap != r_rd_wrap);
    assign item_commit = (item_c == CH_LF) || (item_c == CH_EOT) || (item_c == CH_ETX)
                         || full_after;
    assign len_cap     = (i_read_length > MaxLen) ? MaxLen : i_read_length;
    assign out_free    = !r_out_valid || o_out.ready;

    cleb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rx_store),
        .i_waddr (r_ed_idx),
        .i_wdata (item_c),
        .i_re    (i_cmd.rd_fetch),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        o_stat.out_free   = out_free;
        o_stat.op         = r_op;
        o_stat.item_zero  = (r_byte == CH_NUL);
        o_stat.item_del   = (r_byte == CH_DEL);
        o_stat.item_lf    = (item_c == CH_LF);
        o_stat.can_erase  = (r_ed_idx != r_cm_idx) || (r_ed_wrap != r_cm_wrap);
        o_stat.full       = full;
        o_stat.n_zero     = (r_len == '0);
        o_stat.empty      = (r_rd_idx == r_cm_idx) && (r_rd_wrap == r_cm_wrap);
        o_stat.rdata_ctl  = (rdata == CH_EOT) || (rdata == CH_ETX);
        o_stat.rdata_lf   = (rdata == CH_LF);
        o_stat.last_take  = ((r_taken + 7'd1) == r_len);
        o_stat.rd_next_cm = (rd_inc_idx == r_cm_idx) && (rd_inc_wrap == r_cm_wrap);
    end

    always_comb begin
        case (i_cmd.src)
            SRC_ZERO:  emit_byte = CH_NUL;
            SRC_ITEM:  emit_byte = item_c;
            SRC_BS:    emit_byte = CH_BS;
            SRC_SP:    emit_byte = CH_SP;
            SRC_CR:    emit_byte = CH_CR;
            SRC_RDATA: emit_byte = rdata;
            SRC_PEND:  emit_byte = r_pend;
            default:   emit_byte = CH_NUL;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_rd_wrap   <= 1'b0;
            r_cm_idx    <= '0;
            r_cm_wrap   <= 1'b0;
            r_ed_idx    <= '0;
            r_ed_wrap   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.rx_store) begin
                r_ed_idx  <= ed_inc_idx;
                r_ed_wrap <= ed_inc_wrap;
                if (item_commit) begin
                    r_cm_idx  <= ed_inc_idx;
                    r_cm_wrap <= ed_inc_wrap;
                end
            end else if (i_cmd.rx_del) begin
                r_ed_idx  <= ed_dec_idx;
                r_ed_wrap <= ed_dec_wrap;
            end
            if (i_cmd.rd_consume) begin
                r_rd_idx  <= rd_inc_idx;
                r_rd_wrap <= rd_inc_wrap;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_byte  <= i_rx_byte;
            r_len   <= len_cap;
            r_taken <= '0;
        end else if (i_cmd.rd_consume) begin
            r_taken <= r_taken + 7'd1;
        end
        if (i_cmd.rd_consume) begin
            r_pend <= rdata;
        end
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_byte <= emit_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result emitted over an untaken transaction");
    a_del_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rx_del |-> o_stat.can_erase)
        else $error("erase past the commit pointer");
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rx_store |-> !full)
        else $error("store into a full buffer");
    a_consume_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_consume |-> !o_stat.empty)
        else $error("read beyond the commit pointer");
endmodule
`default_nettype wire

// ----- hdl/cleb_ctrl.sv -----
// Controller: sequences receive edits, echoes and read walks.
`default_nettype none
module cleb_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  cleb_pkg::t_stat i_stat,
    output cleb_pkg::t_cmd  o_cmd
);
    import cleb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_DEL_SP   = 9'b000000100,
        S_DEL_BS   = 9'b000001000,
        S_ECHO_CR  = 9'b000010000,
        S_FETCH    = 9'b000100000,
        S_EXAM     = 9'b001000000,
        S_FETCH_P  = 9'b010000000,
        S_EXAM_P   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = K_NONE;
        o_cmd.src  = SRC_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op == OP_RECEIVE) begin
                    if (i_stat.item_zero || (i_stat.item_del && !i_stat.can_erase)
                        || (!i_stat.item_del && i_stat.full)) begin
                        if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else if (i_stat.item_del) begin
                        if (i_stat.out_free) begin
                            o_cmd.rx_del = 1'b1;
                            o_cmd.emit   = 1'b1;
                            o_cmd.kind   = K_ECHO;
                            o_cmd.src    = SRC_BS;
                            n_state      = S_DEL_SP;
                        end
                    end else if (i_stat.out_free) begin
                        o_cmd.rx_store = 1'b1;
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = K_ECHO;
                        o_cmd.src      = SRC_ITEM;
                        o_cmd.last     = !i_stat.item_lf;
                        n_state        = i_stat.item_lf ? S_ECHO_CR : S_IDLE;
                    end
                end else if (i_stat.n_zero || i_stat.empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = i_stat.n_zero ? K_NONE : K_EMPTY;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DEL_SP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_ECHO;
                    o_cmd.src  = SRC_SP;
                    n_state    = S_DEL_BS;
                end
            end
            S_DEL_BS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_ECHO;
                    o_cmd.src  = SRC_BS;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ECHO_CR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_ECHO;
                    o_cmd.src  = SRC_CR;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FETCH: begin
                o_cmd.rd_fetch = 1'b1;
                n_state        = S_EXAM;
            end
            S_FETCH_P: begin
                o_cmd.rd_fetch = 1'b1;
                n_state        = S_EXAM_P;
            end
            S_EXAM: begin
                // nothing held back here; a control code opens the read
                if (i_stat.rdata_ctl) begin
                    if (i_stat.out_free) begin
                        o_cmd.rd_consume = 1'b1;
                        o_cmd.emit       = 1'b1;
                        o_cmd.kind       = K_EOF;
                        o_cmd.src        = SRC_RDATA;
                        o_cmd.last       = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.rdata_lf || i_stat.last_take || i_stat.rd_next_cm) begin
                    if (i_stat.out_free) begin
                        o_cmd.rd_consume = 1'b1;
                        o_cmd.emit       = 1'b1;
                        o_cmd.kind       = K_DATA;
                        o_cmd.src        = SRC_RDATA;
                        o_cmd.last       = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    // hold the byte back until the next one shows it is not the last
                    o_cmd.rd_consume = 1'b1;
                    n_state          = S_FETCH_P;
                end
            end
            S_EXAM_P: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_DATA;
                    o_cmd.src  = SRC_PEND;
                    o_cmd.last = i_stat.rdata_ctl;
                    n_state    = i_stat.rdata_ctl ? S_IDLE : S_EXAM;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- test/cleb_result_checker.sv -----
// Watches both channels of the console buffer, predicts every result and compares it.
module cleb_result_checker #(
    parameter int DEPTH    = 512,
    parameter int MAX_READ = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cleb_in_if   i_in,
    cleb_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import cleb_pkg::*;

    localparam int PW = $clog2(2 * DEPTH);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_console_result;

    logic [7:0]      line_mem [DEPTH];
    logic [PW-1:0]   rd_p = '0;
    logic [PW-1:0]   cm_p = '0;
    logic [PW-1:0]   ed_p = '0;
    t_console_result item_res[$];
    t_console_result awaited_q[$];
    int              fails   = 0;
    int              checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    function automatic void note(input t_kind k, input logic [7:0] d);
        t_console_result r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        item_res.push_back(r);
    endfunction

    function automatic void predict_item(input logic op, input logic [7:0] rx,
                                         input logic [6:0] len);
        logic [PW-1:0]   used;
        logic [7:0]      c;
        int              n;
        int              taken;
        bit              done;
        t_console_result r;
        item_res.delete();
        if (op == OP_RECEIVE) begin
            c = rx;
            used = ed_p - rd_p;
            if (c == CH_DEL) begin
                if (ed_p != cm_p) begin
                    ed_p = ed_p - 1'b1;
                    note(K_ECHO, CH_BS);
                    note(K_ECHO, CH_SP);
                    note(K_ECHO, CH_BS);
                end
            end else if (c != CH_NUL && used < DEPTH) begin
                if (c == CH_CR) c = CH_LF;
                line_mem[ed_p % DEPTH] = c;
                ed_p = ed_p + 1'b1;
                note(K_ECHO, c);
                if (c == CH_LF) note(K_ECHO, CH_CR);
                used = ed_p - rd_p;
                // commit on end of line, end of input, or a full ring
                if (c == CH_LF || c == CH_EOT || c == CH_ETX || used == DEPTH) cm_p = ed_p;
            end
        end else begin
            n = (len > MAX_READ) ? MAX_READ : int'(len);
            if (n != 0 && rd_p == cm_p) begin
                note(K_EMPTY, 8'h00);
            end else if (n != 0) begin
                taken = 0;
                done  = 1'b0;
                while (!done && taken < n && rd_p != cm_p) begin
                    c = line_mem[rd_p % DEPTH];
                    if (c == CH_EOT || c == CH_ETX) begin
                        // consume the mark only at the start of a read, else leave it
                        if (taken == 0) begin
                            rd_p = rd_p + 1'b1;
                            note(K_EOF, c);
                        end
                        done = 1'b1;
                    end else begin
                        rd_p = rd_p + 1'b1;
                        note(K_DATA, c);
                        taken++;
                        done = (c == CH_LF);
                    end
                end
            end
        end
        if (item_res.size() == 0) note(K_NONE, 8'h00);
        r = item_res.pop_back();
        r.last = 1'b1;
        item_res.push_back(r);
        foreach (item_res[i]) awaited_q.push_back(item_res[i]);
    endfunction

    always @(posedge i_clk) begin
        t_console_result exp_r;
        if (!i_rst_n) begin
            rd_p = '0;
            cm_p = '0;
            ed_p = '0;
            awaited_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                predict_item(i_in.operation, i_in.rx_byte, i_in.read_length);
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (awaited_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t unexpected result: kind %0d byte 0x%02h last %0b",
                                 $time, i_out.kind, i_out.out_byte, i_out.last);
                end else begin
                    exp_r = awaited_q.pop_front();
                    if (i_out.kind !== exp_r.kind || i_out.out_byte !== exp_r.data ||
                        i_out.last !== exp_r.last) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t mismatch: expected kind %0d byte 0x%02h last %0b,",
                                      " got kind %0d byte 0x%02h last %0b"},
                                     $time, exp_r.kind, exp_r.data, exp_r.last,
                                     i_out.kind, i_out.out_byte, i_out.last);
                    end
                end
            end
        end
        o_pending <= awaited_q.size();
    end

endmodule

// ----- test/tb_console_line_editor_buffer_unit.sv -----
// Top of the console line editor buffer testbench: clock, reset, stimulus and verdict.
module tb_console_line_editor_buffer_unit;
    import cleb_pkg::*;

    localparam int DEPTH        = 512;
    localparam int MAX_READ     = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 430;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   cycles   = 0;
    int   sent_rx  = 0;
    int   sent_rd  = 0;
    bit   no_gaps  = 1'b0;
    bit   hold_out = 1'b0;

    cleb_in_if  in_ch ();
    cleb_out_if out_ch ();

    console_line_editor_buffer_unit #(
        .BUFFER_DEPTH(DEPTH),
        .MAX_READ    (MAX_READ)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    cleb_result_checker #(
        .DEPTH   (DEPTH),
        .MAX_READ(MAX_READ)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall before each transaction, plus one long hold on request.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic op, input logic [7:0] rx, input logic [6:0] len);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.rx_byte     <= rx;
        in_ch.read_length <= len;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (op == OP_RECEIVE) sent_rx++;
        else sent_rd++;
    endtask

    task automatic key_in(input logic [7:0] c);
        send_item(OP_RECEIVE, c, 7'($urandom));
    endtask

    task automatic read_req(input logic [6:0] len);
        send_item(OP_READ, 8'($urandom), len);
    endtask

    // Hold the input idle until every predicted result has been seen.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [6:0] any_length();
        int p = $urandom_range(0, 19);
        if (p < 2) return 7'd0;
        if (p < 5) return 7'($urandom_range(65, 127));
        return 7'($urandom_range(1, MAX_READ));
    endfunction

    // Line of printable text with occasional erase and raw bytes, then a terminator.
    task automatic type_line(input int len, input logic [7:0] term);
        int pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) key_in(CH_DEL);
            else if (pick == 2) key_in(8'($urandom));
            else key_in(8'($urandom_range(8'h20, 8'h7e)));
        end
        key_in(term);
    endtask

    // Overrun the ring without a line end, then read it back out.
    task automatic fill_buffer(input bit with_hold);
        for (int i = 0; i < DEPTH + 20; i++) begin
            if (with_hold && i == 8) hold_out = 1'b1;
            key_in(8'($urandom_range(8'h20, 8'h7e)));
        end
        key_in(CH_DEL);
        key_in(CH_CR);
        drain_results();
        for (int i = 0; i < DEPTH / MAX_READ + 4; i++) read_req(7'(MAX_READ));
        drain_results();
    endtask

    initial begin
        int         rnd_base;
        int         done_items;
        int         mark;
        int         choice;
        bit         refilled;
        logic [7:0] term;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_RECEIVE;
        in_ch.rx_byte     = 8'h00;
        in_ch.read_length = 7'd0;
        i_rst_n           = 1'b0;
        refilled          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty read, zero length, ignored bytes, erase, CR, EOF marks, capping
        read_req(7'd5);
        read_req(7'd0);
        key_in(CH_NUL);
        key_in(CH_DEL);
        key_in("a");
        key_in(8'hff);
        key_in(8'h80);
        key_in(CH_DEL);
        key_in(CH_CR);
        read_req(7'd1);
        read_req(7'd127);
        key_in("x");
        key_in(CH_EOT);
        key_in(CH_ETX);
        read_req(7'd64);
        read_req(7'd64);
        read_req(7'd64);
        read_req(7'd64);
        key_in("q");
        key_in("r");
        read_req(7'd10);
        key_in(CH_LF);
        read_req(7'd65);
        key_in(CH_LF);
        read_req(7'd1);
        drain_results();

        fill_buffer(1'b1);

        rnd_base = sent_rx + sent_rd;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            no_gaps = (done_items >= 120 && done_items < 200);
            if (!refilled && done_items >= 220) begin
                drain_results();
                mark = sent_rx + sent_rd;
                fill_buffer(1'b0);
                rnd_base += (sent_rx + sent_rd) - mark;
                refilled = 1'b1;
            end
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: term = CH_CR;
                    4, 5:       term = CH_LF;
                    6:          term = CH_EOT;
                    7:          term = CH_ETX;
                    default:    term = CH_NUL;
                endcase
                type_line($urandom_range(0, 12), term);
                repeat ($urandom_range(0, 2)) read_req(any_length());
            end else if (choice < 9) begin
                repeat ($urandom_range(1, 3)) read_req(any_length());
            end else begin
                send_item(1'($urandom), 8'($urandom), 7'($urandom));
            end
            done_items = (sent_rx + sent_rd) - rnd_base;
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (40) @(negedge i_clk);

        $display("Sent %0d received bytes and %0d read requests; %0d results checked.",
                 sent_rx, sent_rd, checked);
        $display("Run took in line editing, EOF marks, empty and capped reads, two ring fills,");
        $display("pointer wrap and a %0d-cycle output stall.", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
